// ----- sv/tdts_pkg.sv -----
package tdts_pkg;

   localparam int DEF_MAX_TOKEN_CHARS = 8;
   localparam int DEF_KEYWORD_COUNT   = 12;
   localparam int DEF_LINE_BITS       = 16;

   localparam int TEXT_BYTES  = 8;
   localparam int TABLE_SIZE  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_ABITS = $clog2(QUEUE_DEPTH);

   // token classes
   localparam logic [3:0] CLS_IDENT   = 4'd0;
   localparam logic [3:0] CLS_NUM     = 4'd1;
   localparam logic [3:0] CLS_ASSIGN  = 4'd2;
   localparam logic [3:0] CLS_RELAT   = 4'd3;
   localparam logic [3:0] CLS_ARITH   = 4'd4;
   localparam logic [3:0] CLS_COMMA   = 4'd5;
   localparam logic [3:0] CLS_PAREN   = 4'd6;
   localparam logic [3:0] CLS_DELIM   = 4'd7;
   localparam logic [3:0] CLS_KEYWORD = 4'd8;
   localparam logic [3:0] CLS_EOF     = 4'd9;
   localparam logic [3:0] CLS_LONG    = 4'd10;
   localparam logic [3:0] CLS_INVALID = 4'd11;

   localparam logic [7:0]  CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0]  CHAR_HASH    = 8'h23;
   localparam logic [63:0] EOF_TEXT     = 64'h0000_0000_0046_4f45;
   localparam logic [3:0]  EOF_LENGTH   = 4'd3;

   localparam logic [63:0] KW_TEXT [TABLE_SIZE] = '{
      64'h0000_0074_7261_7473,   // start
      64'h0000_0000_706f_7473,   // stop
      64'h0065_7461_7265_7469,   // iterate
      64'h0000_0000_6469_6f76,   // void
      64'h0000_0000_0072_6176,   // var
      64'h0000_6e72_7574_6572,   // return
      64'h0000_0000_0000_6e69,   // in
      64'h0000_0000_0074_756f,   // out
      64'h006d_6172_676f_7270,   // program
      64'h0000_0000_646e_6f63,   // cond
      64'h0000_0000_6e65_6874,   // then
      64'h0000_0000_0074_656c,   // let
      64'h0, 64'h0, 64'h0, 64'h0
   };

   localparam logic [3:0] KW_LENGTH [TABLE_SIZE] = '{
      4'd5, 4'd4, 4'd7, 4'd4, 4'd3, 4'd6, 4'd2, 4'd3,
      4'd7, 4'd4, 4'd4, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0
   };

   typedef struct packed {
      logic [3:0]  token_class;
      logic [63:0] token_text;
      logic [3:0]  text_length;
      logic [15:0] line_number;
      logic        last;
   } tok_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type    first;
      tok_type    second;
   } push_type;

endpackage

// ----- sv/tdts_core.sv -----
module tdts_core import tdts_pkg::*; #(
   parameter int MAX_TOKEN_CHARS = DEF_MAX_TOKEN_CHARS,
   parameter int KEYWORD_COUNT   = DEF_KEYWORD_COUNT,
   parameter int LINE_BITS       = DEF_LINE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] character,
   input  logic       end_of_input,
   output push_type   push
);

   // scanner states
   localparam logic [4:0] ST_START    = 5'd0;
   localparam logic [4:0] ST_ID_FIRST = 5'd1;
   localparam logic [4:0] ST_ID_LAST  = 5'd8;
   localparam logic [4:0] ST_NUM_FIRST = 5'd9;
   localparam logic [4:0] ST_NUM_LAST = 5'd16;
   localparam logic [4:0] ST_ASSIGN   = 5'd17;
   localparam logic [4:0] ST_EQEQ     = 5'd18;
   localparam logic [4:0] ST_REL      = 5'd19;
   localparam logic [4:0] ST_ARITH    = 5'd20;
   localparam logic [4:0] ST_COMMA    = 5'd21;
   localparam logic [4:0] ST_BRACKET  = 5'd22;
   localparam logic [4:0] ST_DELIM    = 5'd23;

   // character classes
   localparam logic [4:0] K_SPACE   = 5'd0;
   localparam logic [4:0] K_LOWER   = 5'd1;
   localparam logic [4:0] K_UPPER   = 5'd2;
   localparam logic [4:0] K_DIGIT   = 5'd3;
   localparam logic [4:0] K_EQUAL   = 5'd4;
   localparam logic [4:0] K_LESS    = 5'd5;
   localparam logic [4:0] K_GREATER = 5'd6;
   localparam logic [4:0] K_ARITH   = 5'd7;
   localparam logic [4:0] K_COMMA   = 5'd12;
   localparam logic [4:0] K_BRACKET = 5'd13;
   localparam logic [4:0] K_DELIM   = 5'd19;
   localparam logic [4:0] K_OTHER   = 5'd22;

   // transition kinds
   localparam logic [1:0] ACT_GOTO    = 2'd0;
   localparam logic [1:0] ACT_FINISH  = 2'd1;
   localparam logic [1:0] ACT_INVALID = 2'd2;
   localparam logic [1:0] ACT_LONG    = 2'd3;

   typedef struct packed {
      logic [1:0] act;
      logic [4:0] target;
      logic [3:0] cls;
   } move_type;

   logic [4:0]           state_ff, state_in;
   logic [63:0]          text_ff, text_in;
   logic [3:0]           count_ff, count_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic                 comment_ff, comment_in;
   logic                 halted_ff, halted_in;

   logic [31:0]          line_wide;
   logic [15:0]          line_out;
   logic [LINE_BITS-1:0] line_bump;
   logic [4:0]           kind;
   move_type             move;
   logic [1:0]           act;
   logic [63:0]          text_new;
   logic [3:0]           count_new;
   push_type             result;

   function automatic logic [4:0] classify(input logic [7:0] c);
      logic [4:0] k;
      case (c) inside
         8'd32, [8'd9:8'd13]:               k = K_SPACE;
         ["a":"z"]:                         k = K_LOWER;
         ["A":"Z"]:                         k = K_UPPER;
         ["0":"9"]:                         k = K_DIGIT;
         "=":                               k = K_EQUAL;
         "<":                               k = K_LESS;
         ">":                               k = K_GREATER;
         "+", "-", "*", "/", "%":           k = K_ARITH;
         ",":                               k = K_COMMA;
         "(", ")", "{", "}", "[", "]":      k = K_BRACKET;
         ":", ".", ";":                     k = K_DELIM;
         default:                           k = K_OTHER;
      endcase
      return k;
   endfunction

   function automatic logic [3:0] finish_class(input logic [4:0] s);
      logic [3:0] c;
      case (s) inside
         [ST_ID_FIRST:ST_ID_LAST]:   c = CLS_IDENT;
         [ST_NUM_FIRST:ST_NUM_LAST]: c = CLS_NUM;
         ST_ASSIGN:                  c = CLS_ASSIGN;
         ST_EQEQ, ST_REL:            c = CLS_RELAT;
         ST_ARITH:                   c = CLS_ARITH;
         ST_COMMA:                   c = CLS_COMMA;
         ST_BRACKET:                 c = CLS_PAREN;
         default:                    c = CLS_DELIM;
      endcase
      return c;
   endfunction

   function automatic move_type advance(input logic [4:0] s, input logic [4:0] k);
      move_type m;
      m.act    = ACT_INVALID;
      m.target = s;
      m.cls    = finish_class(s);
      if (k == K_SPACE) begin
         if (s == ST_START) begin
            m.act = ACT_GOTO;
         end else if (s <= ST_DELIM) begin
            m.act = ACT_FINISH;
         end
      end else if (s == ST_START) begin
         m.act = ACT_GOTO;
         case (k)
            K_LOWER:            m.target = ST_ID_FIRST;
            K_DIGIT:            m.target = ST_NUM_FIRST;
            K_EQUAL:            m.target = ST_ASSIGN;
            K_LESS, K_GREATER:  m.target = ST_REL;
            K_ARITH:            m.target = ST_ARITH;
            K_COMMA:            m.target = ST_COMMA;
            K_BRACKET:          m.target = ST_BRACKET;
            K_DELIM:            m.target = ST_DELIM;
            default:            m.act = ACT_INVALID;
         endcase
      end else if (s <= ST_ID_LAST) begin
         if (k == K_LOWER || k == K_UPPER || k == K_DIGIT) begin
            m.act    = (s == ST_ID_LAST) ? ACT_LONG : ACT_GOTO;
            m.target = s + 5'd1;
         end
      end else if (s <= ST_NUM_LAST) begin
         if (k == K_DIGIT) begin
            m.act    = (s == ST_NUM_LAST) ? ACT_LONG : ACT_GOTO;
            m.target = s + 5'd1;
         end
      end else if ((s == ST_ASSIGN || s == ST_REL) && k == K_EQUAL) begin
         m.act    = ACT_GOTO;
         m.target = ST_EQEQ;
      end
      return m;
   endfunction

   function automatic logic is_keyword(input logic [63:0] t, input logic [3:0] n);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         if (KW_LENGTH[i] != 4'd0 && KW_LENGTH[i] == n && KW_TEXT[i] == t) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   assign line_wide = 32'(line_ff);
   assign line_out  = line_wide[15:0];
   assign line_bump = (line_ff == '1) ? line_ff : line_ff + 1'b1;
   assign kind      = classify(character);
   assign move      = advance(state_ff, kind);

   always_comb begin
      text_new  = text_ff;
      count_new = count_ff;
      if (kind != K_SPACE) begin
         for (int i = 0; i < TEXT_BYTES; i++) begin
            if (count_ff == 4'(i)) begin
               text_new[8*i +: 8] = character;
            end
         end
         if (count_ff < 4'd9) begin
            count_new = count_ff + 4'd1;
         end
      end
      act = move.act;
      if (act == ACT_GOTO && state_ff != ST_START && count_new > 4'(MAX_TOKEN_CHARS)) begin
         act = ACT_LONG;
      end
      if (act == ACT_GOTO && move.target != ST_START && count_new > 4'(MAX_TOKEN_CHARS)) begin
         act = ACT_LONG;
      end
   end

   always_comb begin
      state_in   = state_ff;
      text_in    = text_ff;
      count_in   = count_ff;
      line_in    = line_ff;
      comment_in = comment_ff;
      halted_in  = halted_ff;
      result     = '0;
      result.first.line_number  = line_out;
      result.second.line_number = line_out;
      if (!halted_ff) begin
         if (end_of_input) begin
            if (state_ff != ST_START) begin
               result.count             = 2'd2;
               result.first.token_class = (finish_class(state_ff) == CLS_IDENT &&
                                           is_keyword(text_ff, count_ff)) ?
                                          CLS_KEYWORD : finish_class(state_ff);
               result.first.token_text  = text_ff;
               result.first.text_length = count_ff;
               result.second.token_class = CLS_EOF;
               result.second.token_text  = EOF_TEXT;
               result.second.text_length = EOF_LENGTH;
               result.second.last        = 1'b1;
            end else begin
               result.count             = 2'd1;
               result.first.token_class = CLS_EOF;
               result.first.token_text  = EOF_TEXT;
               result.first.text_length = EOF_LENGTH;
               result.first.last        = 1'b1;
            end
            state_in   = ST_START;
            text_in    = '0;
            count_in   = '0;
            comment_in = 1'b0;
         end else if (comment_ff) begin
            if (character == CHAR_NEWLINE) begin
               comment_in = 1'b0;
               line_in    = line_bump;
            end
         end else if (character == CHAR_HASH) begin
            comment_in = 1'b1;
         end else begin
            unique case (act)
               ACT_INVALID, ACT_LONG: begin
                  result.count             = 2'd1;
                  result.first.token_class = (act == ACT_LONG) ? CLS_LONG : CLS_INVALID;
                  result.first.token_text  = text_new;
                  result.first.text_length = count_new;
                  result.first.last        = 1'b1;
                  text_in                  = text_new;
                  count_in                 = count_new;
                  halted_in                = 1'b1;
               end
               ACT_FINISH: begin
                  result.count             = 2'd1;
                  result.first.token_class = (move.cls == CLS_IDENT &&
                                              is_keyword(text_new, count_new)) ?
                                             CLS_KEYWORD : move.cls;
                  result.first.token_text  = text_new;
                  result.first.text_length = count_new;
                  result.first.last        = 1'b1;
                  state_in                 = ST_START;
                  text_in                  = '0;
                  count_in                 = '0;
               end
               default: begin
                  state_in = move.target;
                  text_in  = text_new;
                  count_in = count_new;
               end
            endcase
            if (act != ACT_INVALID && act != ACT_LONG && character == CHAR_NEWLINE) begin
               line_in = line_bump;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_START;
         text_ff    <= '0;
         count_ff   <= '0;
         line_ff    <= LINE_BITS'(1);
         comment_ff <= 1'b0;
         halted_ff  <= 1'b0;
      end else if (take) begin
         state_ff   <= state_in;
         text_ff    <= text_in;
         count_ff   <= count_in;
         line_ff    <= line_in;
         comment_ff <= comment_in;
         halted_ff  <= halted_in;
      end
   end

   always_comb begin
      push       = result;
      push.count = take ? result.count : 2'd0;
   end

   assert property (@(posedge clock) disable iff (reset) halted_ff |=> halted_ff)
      else $error("scanner left halt without reset");
   assert property (@(posedge clock) disable iff (reset) halted_ff |-> push.count == 2'd0)
      else $error("result produced while halted");
   assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.first.last && push.second.last)
      else $error("last flag misplaced on pair of results");
   assert property (@(posedge clock) disable iff (reset) line_ff != '0)
      else $error("line counter reached zero");

endmodule

// ----- sv/tdts_queue.sv -----
module tdts_queue import tdts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output logic     head_valid,
   input  logic     head_stall,
   output tok_type  head
);

   tok_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_ABITS-1:0] wr_ff, wr_in;
   logic [QUEUE_ABITS-1:0] rd_ff, rd_in;
   logic [QUEUE_ABITS:0]   fill_ff, fill_in;
   logic                   pop;

   assign head_valid = fill_ff != '0;
   assign head       = mem_ff[rd_ff];
   assign full       = fill_ff > (QUEUE_ABITS + 1)'(QUEUE_DEPTH - 2);
   assign pop        = head_valid && !head_stall;
   assign wr_in      = wr_ff + QUEUE_ABITS'(push.count);
   assign rd_in      = rd_ff + QUEUE_ABITS'(pop);
   assign fill_in    = fill_ff + (QUEUE_ABITS + 1)'(push.count) - (QUEUE_ABITS + 1)'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + QUEUE_ABITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (QUEUE_ABITS + 1)'(QUEUE_DEPTH))
      else $error("result queue overfilled");
   assert property (@(posedge clock) disable iff (reset) full |-> push.count == 2'd0)
      else $error("push into full result queue");
   assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 && push.count != 2'd0 |=> head_valid)
      else $error("pushed word not presented");

endmodule

// ----- sv/table_driven_token_scanner_unit.sv -----
// table driven token scanner
//
// req channel: one word per accepted cycle, req_character plus req_end_of_input.
// a word is taken when req_valid is high and req_stall is low.
// rsp channel: token words with class, text, length, line and last flag.
// a word leaves when rsp_valid is high and rsp_stall is low.
//
// each input word is scanned in the cycle it is accepted; its tokens enter a
// four-word result queue, whose head word drives rsp.
// throughput: one input word per cycle while req_stall is low; an end of input
// that closes a pending token yields two rsp words.
// the rate is set by the result queue: req_stall rises when fewer than two
// queue slots are free.
// rsp_stall holds the head word; the queue fills and then stalls req.
// reset clears the scanner to the start state, line 1, and empties the queue.
// after an error token every input word is taken and dropped until reset.
module table_driven_token_scanner_unit import tdts_pkg::*; #(
   parameter int MAX_TOKEN_CHARS = DEF_MAX_TOKEN_CHARS,
   parameter int KEYWORD_COUNT   = DEF_KEYWORD_COUNT,
   parameter int LINE_BITS       = DEF_LINE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_class,
   output logic [63:0] rsp_token_text,
   output logic [3:0]  rsp_text_length,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last
);

   push_type push;
   tok_type  head;
   logic     full;
   logic     take;

   assign req_stall = full;
   assign take      = req_valid && !full;

   tdts_core #(
      .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
      .KEYWORD_COUNT   (KEYWORD_COUNT),
      .LINE_BITS       (LINE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .character    (req_character),
      .end_of_input (req_end_of_input),
      .push         (push)
   );

   tdts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .head_valid (rsp_valid),
      .head_stall (rsp_stall),
      .head       (head)
   );

   assign rsp_token_class = head.token_class;
   assign rsp_token_text  = head.token_text;
   assign rsp_text_length = head.text_length;
   assign rsp_line_number = head.line_number;
   assign rsp_last        = head.last;

endmodule
